[hw/rtl/gab_pkg.sv]
// Shared types, constants and lookup tables for the glyph alpha blender.
// No dependencies; every other file of the block imports this package.
package gab_pkg;

    typedef enum logic [2:0] {
        REG_GLYPH_COLOR   = 3'd0,
        REG_HIGHLIGHT_ON  = 3'd1,
        REG_CENTER_X      = 3'd2,
        REG_CENTER_Y      = 3'd3,
        REG_GLYPH_SIZE    = 3'd4,
        REG_SCREEN_WIDTH  = 3'd5,
        REG_SCREEN_HEIGHT = 3'd6
    } cfg_reg_t;

    typedef logic [7:0] chan8_t;
    typedef chan8_t exp5_lut_t [32];
    typedef chan8_t exp6_lut_t [64];

    // Channel expansion c*255/31 and c*255/63, truncated, built at elaboration.
    function automatic exp5_lut_t build_exp5();
        exp5_lut_t t;
        for (int i = 0; i < 32; i++) begin
            t[i] = 8'(i * 255 / 31);
        end
        return t;
    endfunction

    function automatic exp6_lut_t build_exp6();
        exp6_lut_t t;
        for (int i = 0; i < 64; i++) begin
            t[i] = 8'(i * 255 / 63);
        end
        return t;
    endfunction

    localparam exp5_lut_t EXP5 = build_exp5();
    localparam exp6_lut_t EXP6 = build_exp6();

    // Halo applies only for coverage strictly above this value.
    localparam logic [7:0] HALO_MIN = 8'd32;
    // Halo blend denominator and its reciprocal: floor(x*RECIP/2^28) == x/1275
    // for every sum the halo blend can produce.
    localparam logic [10:0] HALO_DEN    = 11'd1275;
    localparam logic [17:0] RECIP_1275  = 18'd210538;
    localparam int          RecipShift  = 28;

    typedef struct packed {
        logic        keep;
        logic [10:0] px;
        logic [10:0] py;
    } place_t;

    function automatic logic [15:0] pack565(input chan8_t r, input chan8_t g, input chan8_t b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

[hw/rtl/gab_place.sv]
// Glyph pixel placement and screen clipping for the glyph alpha blender.
// Depends on gab_pkg for the place_t result struct.
module gab_place #(
    parameter int MAX_GLYPH_SIZE = 64,
    parameter int SCREEN_LIMIT   = 2048
) (
    input  logic [11:0]     center_x,
    input  logic [11:0]     center_y,
    input  logic [6:0]      glyph_size,
    input  logic [11:0]     screen_width,
    input  logic [11:0]     screen_height,
    input  logic [7:0]      coverage,
    input  logic [5:0]      col_offset,
    input  logic [5:0]      row_offset,
    output gab_pkg::place_t place
);
    import gab_pkg::*;

    logic [6:0]         size_sat;
    logic [11:0]        sw_sat;
    logic [11:0]        sh_sat;
    logic signed [13:0] px_full;
    logic signed [13:0] py_full;
    logic               in_glyph;
    logic               on_screen;

    always_comb begin
        size_sat = (int'(glyph_size) > MAX_GLYPH_SIZE) ? 7'(MAX_GLYPH_SIZE) : glyph_size;
        sw_sat   = (int'(screen_width) > SCREEN_LIMIT) ? 12'(SCREEN_LIMIT) : screen_width;
        sh_sat   = (int'(screen_height) > SCREEN_LIMIT) ? 12'(SCREEN_LIMIT) : screen_height;

        // Top-left corner sits half a glyph (rounded down) before the center.
        px_full = $signed({{2{center_x[11]}}, center_x}) - $signed({8'b0, size_sat[6:1]})
                + $signed({8'b0, col_offset});
        py_full = $signed({{2{center_y[11]}}, center_y}) - $signed({8'b0, size_sat[6:1]})
                + $signed({8'b0, row_offset});

        in_glyph  = (coverage != 8'd0) && (size_sat != 7'd0)
                  && ({1'b0, col_offset} < size_sat) && ({1'b0, row_offset} < size_sat);
        on_screen = !px_full[13] && !py_full[13]
                  && (px_full[12:0] < {1'b0, sw_sat}) && (py_full[12:0] < {1'b0, sh_sat});

        place.keep = in_glyph && on_screen;
        place.px   = px_full[10:0];
        place.py   = py_full[10:0];
    end

endmodule

[hw/rtl/glyph_alpha_blend_rgb565.sv]
// Top level of the glyph alpha blender: configuration registers and the blend pipeline.
// Depends on gab_pkg and on gab_place for pixel placement and clipping.
//
// Usage: each transaction on the s_ channel carries one glyph pixel (coverage, the
// background RGB565 pixel at its target position, and its column and row inside the
// glyph square). Each yields exactly one transaction on the m_ channel: a write enable,
// the screen position and the blended RGB565 value. When the write enable is low the
// position and value are zero. The cfg_ port writes one register per cycle in which
// cfg_we is high; it must only be used while no transaction is in flight.
// Throughput is one pixel per cycle while m_ready is high. Six register stages lie
// between acceptance and m_valid: placement and background expansion, glyph-over-
// background products, divide by 255 and repack, halo products, reciprocal multiply
// for the divide by 1275, and the output register.
// Reset clears every stage valid bit and loads the register defaults (white glyph,
// halo off, center 0,0, size 32, 240 by 240 screen).
// When the receiver holds m_ready low, stages behind the output keep filling until
// every stage holds a pixel; only then does s_ready drop. No pixel is lost or repeated.
module glyph_alpha_blend_rgb565 #(
    parameter int MAX_GLYPH_SIZE = 64,
    parameter int SCREEN_LIMIT   = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_coverage,
    input  logic [15:0] s_background,
    input  logic [5:0]  s_col_offset,
    input  logic [5:0]  s_row_offset,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_enable,
    output logic [10:0] m_pixel_x,
    output logic [10:0] m_pixel_y,
    output logic [15:0] m_pixel_value
);
    import gab_pkg::*;

    localparam int NumStages = 6;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] glyph_color_reg;
    logic        highlight_on_reg;
    logic [11:0] center_x_reg;
    logic [11:0] center_y_reg;
    logic [6:0]  glyph_size_reg;
    logic [11:0] screen_width_reg;
    logic [11:0] screen_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_color_reg   <= 16'hFFFF;
            highlight_on_reg  <= 1'b0;
            center_x_reg      <= 12'd0;
            center_y_reg      <= 12'd0;
            glyph_size_reg    <= 7'd32;
            screen_width_reg  <= 12'd240;
            screen_height_reg <= 12'd240;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_GLYPH_COLOR:   glyph_color_reg   <= cfg_wdata;
                REG_HIGHLIGHT_ON:  highlight_on_reg  <= cfg_wdata[0];
                REG_CENTER_X:      center_x_reg      <= cfg_wdata[11:0];
                REG_CENTER_Y:      center_y_reg      <= cfg_wdata[11:0];
                REG_GLYPH_SIZE:    glyph_size_reg    <= cfg_wdata[6:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata[11:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // Glyph and halo colors expanded to 8 bits per channel. These depend only on
    // configuration, which is stable while pixels are in flight.
    chan8_t glyph_r8, glyph_g8, glyph_b8;
    chan8_t halo_r8, halo_g8, halo_b8;

    always_comb begin
        glyph_r8 = EXP5[glyph_color_reg[15:11]];
        glyph_g8 = EXP6[glyph_color_reg[10:5]];
        glyph_b8 = EXP5[glyph_color_reg[4:0]];
        // Halving and repacking keeps the top bits of the halved channel, which is
        // the expanded channel shifted right once more; then it is expanded again.
        halo_r8  = EXP5[{1'b0, glyph_r8[7:4]}];
        halo_g8  = EXP6[{1'b0, glyph_g8[7:3]}];
        halo_b8  = EXP5[{1'b0, glyph_b8[7:4]}];
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage takes new data when it is empty or when the
    // stage after it takes its data.
    // ------------------------------------------------------------------
    logic [NumStages-1:0] vld_reg;
    logic [NumStages-1:0] vld_next;
    logic [NumStages-1:0] stg_rdy;

    always_comb begin
        stg_rdy[NumStages-1] = !vld_reg[NumStages-1] || m_ready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            stg_rdy[k] = !vld_reg[k] || stg_rdy[k+1];
        end
        vld_next[0] = stg_rdy[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < NumStages; k++) begin
            vld_next[k] = stg_rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = stg_rdy[0];

    // ------------------------------------------------------------------
    // Stage 1: placement, clipping, halo decision, background expansion
    // ------------------------------------------------------------------
    place_t place_next;

    gab_place #(
        .MAX_GLYPH_SIZE (MAX_GLYPH_SIZE),
        .SCREEN_LIMIT   (SCREEN_LIMIT)
    ) u_place (
        .center_x      (center_x_reg),
        .center_y      (center_y_reg),
        .glyph_size    (glyph_size_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .coverage      (s_coverage),
        .col_offset    (s_col_offset),
        .row_offset    (s_row_offset),
        .place         (place_next)
    );

    place_t s1_place_reg;
    logic [7:0] s1_a_reg;
    logic       s1_halo_reg;
    chan8_t     s1_br_reg, s1_bg_reg, s1_bb_reg;

    always_ff @(posedge aclk) begin
        if (stg_rdy[0]) begin
            s1_place_reg <= place_next;
            s1_a_reg     <= s_coverage;
            s1_halo_reg  <= highlight_on_reg && (s_coverage > HALO_MIN);
            s1_br_reg    <= EXP5[s_background[15:11]];
            s1_bg_reg    <= EXP6[s_background[10:5]];
            s1_bb_reg    <= EXP5[s_background[4:0]];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: f*a + b*(255-a) per channel
    // ------------------------------------------------------------------
    logic [7:0]  inv_a;
    logic [15:0] sum_r_next, sum_g_next, sum_b_next;

    always_comb begin
        inv_a      = 8'd255 - s1_a_reg;
        sum_r_next = ({8'b0, glyph_r8} * {8'b0, s1_a_reg}) + ({8'b0, s1_br_reg} * {8'b0, inv_a});
        sum_g_next = ({8'b0, glyph_g8} * {8'b0, s1_a_reg}) + ({8'b0, s1_bg_reg} * {8'b0, inv_a});
        sum_b_next = ({8'b0, glyph_b8} * {8'b0, s1_a_reg}) + ({8'b0, s1_bb_reg} * {8'b0, inv_a});
    end

    place_t      s2_place_reg;
    logic [7:0]  s2_a_reg;
    logic        s2_halo_reg;
    logic [15:0] s2_sum_r_reg, s2_sum_g_reg, s2_sum_b_reg;

    always_ff @(posedge aclk) begin
        if (stg_rdy[1]) begin
            s2_place_reg <= s1_place_reg;
            s2_a_reg     <= s1_a_reg;
            s2_halo_reg  <= s1_halo_reg;
            s2_sum_r_reg <= sum_r_next;
            s2_sum_g_reg <= sum_g_next;
            s2_sum_b_reg <= sum_b_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by 255, repack, expand again for the halo blend.
    // (x + (x >> 8) + 1) >> 8 equals x / 255 for every x up to 255*255, which
    // covers every sum the coverage blend can produce.
    // ------------------------------------------------------------------
    logic [16:0] div_r, div_g, div_b;
    chan8_t      q1_r, q1_g, q1_b;

    always_comb begin
        div_r = {1'b0, s2_sum_r_reg} + {9'b0, s2_sum_r_reg[15:8]} + 17'd1;
        div_g = {1'b0, s2_sum_g_reg} + {9'b0, s2_sum_g_reg[15:8]} + 17'd1;
        div_b = {1'b0, s2_sum_b_reg} + {9'b0, s2_sum_b_reg[15:8]} + 17'd1;
        q1_r  = div_r[15:8];
        q1_g  = div_g[15:8];
        q1_b  = div_b[15:8];
    end

    place_t      s3_place_reg;
    logic [7:0]  s3_a_reg;
    logic        s3_halo_reg;
    logic [15:0] s3_blend_reg;
    chan8_t      s3_or_reg, s3_og_reg, s3_ob_reg;

    always_ff @(posedge aclk) begin
        if (stg_rdy[2]) begin
            s3_place_reg <= s2_place_reg;
            s3_a_reg     <= s2_a_reg;
            s3_halo_reg  <= s2_halo_reg;
            s3_blend_reg <= pack565(q1_r, q1_g, q1_b);
            s3_or_reg    <= EXP5[q1_r[7:3]];
            s3_og_reg    <= EXP6[q1_g[7:2]];
            s3_ob_reg    <= EXP5[q1_b[7:3]];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: h*2a + o*(1275-2a) per channel
    // ------------------------------------------------------------------
    logic [8:0]  halo_w;
    logic [10:0] halo_winv;
    logic [18:0] hsum_r_next, hsum_g_next, hsum_b_next;

    always_comb begin
        halo_w      = {s3_a_reg, 1'b0};
        halo_winv   = HALO_DEN - {2'b0, halo_w};
        hsum_r_next = ({11'b0, halo_r8} * {10'b0, halo_w})
                    + ({11'b0, s3_or_reg} * {8'b0, halo_winv});
        hsum_g_next = ({11'b0, halo_g8} * {10'b0, halo_w})
                    + ({11'b0, s3_og_reg} * {8'b0, halo_winv});
        hsum_b_next = ({11'b0, halo_b8} * {10'b0, halo_w})
                    + ({11'b0, s3_ob_reg} * {8'b0, halo_winv});
    end

    place_t      s4_place_reg;
    logic        s4_halo_reg;
    logic [15:0] s4_blend_reg;
    logic [18:0] s4_hsum_r_reg, s4_hsum_g_reg, s4_hsum_b_reg;

    always_ff @(posedge aclk) begin
        if (stg_rdy[3]) begin
            s4_place_reg  <= s3_place_reg;
            s4_halo_reg   <= s3_halo_reg;
            s4_blend_reg  <= s3_blend_reg;
            s4_hsum_r_reg <= hsum_r_next;
            s4_hsum_g_reg <= hsum_g_next;
            s4_hsum_b_reg <= hsum_b_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: multiply by the reciprocal of 1275
    // ------------------------------------------------------------------
    logic [36:0] prod_r_next, prod_g_next, prod_b_next;

    always_comb begin
        prod_r_next = {18'b0, s4_hsum_r_reg} * {19'b0, RECIP_1275};
        prod_g_next = {18'b0, s4_hsum_g_reg} * {19'b0, RECIP_1275};
        prod_b_next = {18'b0, s4_hsum_b_reg} * {19'b0, RECIP_1275};
    end

    place_t      s5_place_reg;
    logic        s5_halo_reg;
    logic [15:0] s5_blend_reg;
    logic [36:0] s5_prod_r_reg, s5_prod_g_reg, s5_prod_b_reg;

    always_ff @(posedge aclk) begin
        if (stg_rdy[4]) begin
            s5_place_reg  <= s4_place_reg;
            s5_halo_reg   <= s4_halo_reg;
            s5_blend_reg  <= s4_blend_reg;
            s5_prod_r_reg <= prod_r_next;
            s5_prod_g_reg <= prod_g_next;
            s5_prod_b_reg <= prod_b_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: output register. A dropped pixel reports zero position and value.
    // ------------------------------------------------------------------
    logic [15:0] value_next;

    always_comb begin
        if (s5_halo_reg) begin
            value_next = pack565(s5_prod_r_reg[RecipShift +: 8], s5_prod_g_reg[RecipShift +: 8],
                                 s5_prod_b_reg[RecipShift +: 8]);
        end else begin
            value_next = s5_blend_reg;
        end
    end

    logic        out_we_reg;
    logic [10:0] out_x_reg;
    logic [10:0] out_y_reg;
    logic [15:0] out_value_reg;

    always_ff @(posedge aclk) begin
        if (stg_rdy[5]) begin
            out_we_reg    <= s5_place_reg.keep;
            out_x_reg     <= s5_place_reg.keep ? s5_place_reg.px : 11'd0;
            out_y_reg     <= s5_place_reg.keep ? s5_place_reg.py : 11'd0;
            out_value_reg <= s5_place_reg.keep ? value_next : 16'd0;
        end
    end

    assign m_valid        = vld_reg[NumStages-1];
    assign m_write_enable = out_we_reg;
    assign m_pixel_x      = out_x_reg;
    assign m_pixel_y      = out_y_reg;
    assign m_pixel_value  = out_value_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The input side only backs up once every stage holds a pixel.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&vld_reg))
        else $error("s_ready low while a pipeline stage is empty");

    // A pixel with zero coverage is never marked for writing.
    a_zero_coverage_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[0] && (s1_a_reg == 8'd0)) |-> !s1_place_reg.keep)
        else $error("zero coverage pixel marked for writing");

    // A dropped pixel reports zero position and value.
    a_drop_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_write_enable) |->
            ((m_pixel_x == 11'd0) && (m_pixel_y == 11'd0) && (m_pixel_value == 16'd0)))
        else $error("dropped pixel carries nonzero fields");

endmodule

[test/glyph_alpha_blend_rgb565_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for glyph_alpha_blend_rgb565: placement, clipping and the
// RGB565 coverage and halo blends, predicted per pixel and checked in transaction order.
// Depends on gab_pkg for the register index type and on the block's top level alone.
module glyph_alpha_blend_rgb565_tb;
    import gab_pkg::*;

    // Geometry limits of the instance; the predictor saturates to the same values.
    localparam int MAX_GLYPH_SIZE = 64;
    localparam int SCREEN_LIMIT   = 2048;

    // Blend weights: coverage over 255, and the halo's doubled coverage over 1275.
    localparam int unsigned COVER_DEN      = 255;
    localparam int unsigned HALO_DEN_TB    = 1275;
    localparam int unsigned HALO_THRESHOLD = 32;

    // Six register stages from acceptance to m_valid; the settle wait follows each drain.
    localparam int SETTLE_CYCLES  = 12;
    // Length of the deliberate sink hold-off that fills the pipeline.
    localparam int RX_HOLD_CYCLES = 300;
    // Cycles without any accepted transaction before the run is declared hung. The
    // longest legal quiet stretch is the hold-off plus one long random stall.
    localparam int STALL_LIMIT    = 4000;
    // Mismatch lines printed before further ones are only counted.
    localparam int MAX_REPORTS    = 100;

    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 200;
    localparam int BACKPRESSURE_LEN = 40;

    // Image of the configuration registers, at their register widths.
    typedef struct packed {
        logic [15:0] color;
        logic        highlight;
        logic [11:0] center_x;
        logic [11:0] center_y;
        logic [6:0]  size;
        logic [11:0] width;
        logic [11:0] height;
    } blend_settings_t;

    // One predicted framebuffer write, laid out like the m_ channel fields.
    typedef struct packed {
        logic        write_enable;
        logic [10:0] x;
        logic [10:0] y;
        logic [15:0] value;
    } pixel_write_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        cfg_we = 1'b0;
    cfg_reg_t    cfg_addr = REG_GLYPH_COLOR;
    logic [15:0] cfg_wdata = '0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_coverage = '0;
    logic [15:0] s_background = '0;
    logic [5:0]  s_col_offset = '0;
    logic [5:0]  s_row_offset = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_write_enable;
    logic [10:0] m_pixel_x;
    logic [10:0] m_pixel_y;
    logic [15:0] m_pixel_value;

    // Predicted writes, oldest first, one per accepted input transaction.
    pixel_write_t    expected_pixels[$];
    // Settings the block holds right now, as last written (or as after reset).
    blend_settings_t active_cfg;
    int              mismatch_count = 0;

    // Pacing controls shared by the source, the sink and the test sequence.
    bit tx_gaps_on   = 1'b1;
    bit rx_stalls_on = 1'b1;
    bit rx_hold      = 1'b0;

    glyph_alpha_blend_rgb565 #(
        .MAX_GLYPH_SIZE (MAX_GLYPH_SIZE),
        .SCREEN_LIMIT   (SCREEN_LIMIT)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_coverage     (s_coverage),
        .s_background   (s_background),
        .s_col_offset   (s_col_offset),
        .s_row_offset   (s_row_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_value  (m_pixel_value)
    );

    // 4 ns clock period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Widen a 5-bit or 6-bit channel to 8 bits with truncating division.
    function automatic int unsigned widen5(input logic [4:0] c);
        int unsigned v;
        v = c;
        return v * 255 / 31;
    endfunction

    function automatic int unsigned widen6(input logic [5:0] c);
        int unsigned v;
        v = c;
        return v * 255 / 63;
    endfunction

    // Repacking keeps only the top bits of each 8-bit channel.
    function automatic logic [15:0] pack_rgb565(input int unsigned r, input int unsigned g,
                                                input int unsigned b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // Weighted blend of fg over bg with weight num/den per 8-bit channel, truncated.
    function automatic logic [15:0] blend565(input logic [15:0] fg, input logic [15:0] bg,
                                             input int unsigned num, input int unsigned den);
        int unsigned fr, fgr, fb, br, bgr, bb, inv;
        fr  = widen5(fg[15:11]);
        fgr = widen6(fg[10:5]);
        fb  = widen5(fg[4:0]);
        br  = widen5(bg[15:11]);
        bgr = widen6(bg[10:5]);
        bb  = widen5(bg[4:0]);
        inv = den - num;
        return pack_rgb565((fr * num + br * inv) / den, (fgr * num + bgr * inv) / den,
                           (fb * num + bb * inv) / den);
    endfunction

    // Expected write for one glyph pixel under the given settings.
    function automatic pixel_write_t predict_pixel(input blend_settings_t c,
                                                   input logic [7:0] cov,
                                                   input logic [15:0] bg,
                                                   input logic [5:0] dx,
                                                   input logic [5:0] dy);
        pixel_write_t res;
        int side, cols, rows, cx, cy, col, row, px, py;
        int unsigned hr, hg, hb;
        logic [15:0] v;
        res  = '0;
        side = c.size;
        cols = c.width;
        rows = c.height;
        if (side > MAX_GLYPH_SIZE) side = MAX_GLYPH_SIZE;
        if (cols > SCREEN_LIMIT) cols = SCREEN_LIMIT;
        if (rows > SCREEN_LIMIT) rows = SCREEN_LIMIT;
        // Assigning through int keeps the sign of the 12-bit centers.
        cx  = $signed(c.center_x);
        cy  = $signed(c.center_y);
        col = dx;
        row = dy;
        px  = cx - side / 2 + col;
        py  = cy - side / 2 + row;
        if (cov == 0 || side == 0 || col >= side || row >= side) return res;
        if (px < 0 || py < 0 || px >= cols || py >= rows) return res;
        v = blend565(c.color, bg, cov, COVER_DEN);
        if (c.highlight && cov > HALO_THRESHOLD) begin
            hr = widen5(c.color[15:11]) >> 1;
            hg = widen6(c.color[10:5]) >> 1;
            hb = widen5(c.color[4:0]) >> 1;
            v  = blend565(pack_rgb565(hr, hg, hb), v, 2 * cov, HALO_DEN_TB);
        end
        res.write_enable = 1'b1;
        res.x            = px[10:0];
        res.y            = py[10:0];
        res.value        = v;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Coverage with weight on zero, opaque and the halo threshold.
    function automatic logic [7:0] pick_coverage();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        if (r == 2) return 8'($urandom_range(31, 34));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic blend_settings_t settings_of(input logic [15:0] color, input logic hl,
                                                    input int cx, input int cy,
                                                    input int size, input int w, input int h);
        blend_settings_t c;
        c.color     = color;
        c.highlight = hl;
        c.center_x  = 12'(cx);
        c.center_y  = 12'(cy);
        c.size      = 7'(size);
        c.width     = 12'(w);
        c.height    = 12'(h);
        return c;
    endfunction

    // Random settings that keep most of the glyph near the visible area, with
    // occasional oversized glyphs and screens and tiny screens.
    function automatic blend_settings_t random_settings();
        blend_settings_t c;
        int pick, cols, rows, pos;
        c.color     = 16'($urandom);
        c.highlight = 1'($urandom_range(0, 1));
        pick   = $urandom_range(0, 9);
        c.size = (pick < 8) ? 7'($urandom_range(1, 64)) : 7'($urandom_range(65, 127));
        pick = $urandom_range(0, 9);
        cols = (pick < 1) ? $urandom_range(1, 63) :
               (pick < 8) ? $urandom_range(64, 2048) : $urandom_range(2049, 4095);
        pick = $urandom_range(0, 9);
        rows = (pick < 1) ? $urandom_range(1, 63) :
               (pick < 8) ? $urandom_range(64, 2048) : $urandom_range(2049, 4095);
        c.width  = 12'(cols);
        c.height = 12'(rows);
        if (cols > SCREEN_LIMIT) cols = SCREEN_LIMIT;
        if (rows > SCREEN_LIMIT) rows = SCREEN_LIMIT;
        // Centers run from a little left of the screen to a little past its far edge.
        pos = int'($urandom_range(0, cols + 80)) - 40;
        if (pos > 2047) pos = 2047;
        c.center_x = 12'(pos);
        pos = int'($urandom_range(0, rows + 80)) - 40;
        if (pos > 2047) pos = 2047;
        c.center_y = 12'(pos);
        return c;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Stops offering pixels and waits until every predicted write has come out,
    // then lets the pipeline settle. Returns at a rising edge.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes every register while the block is idle, one per cycle, then
    // makes the new values the predictor's settings.
    task automatic apply_settings(input blend_settings_t c);
        cfg_reg_t    idx;
        logic [15:0] data;
        drain_results();
        idx = idx.first();
        do begin
            case (idx)
                REG_GLYPH_COLOR:   data = c.color;
                REG_HIGHLIGHT_ON:  data = {15'd0, c.highlight};
                REG_CENTER_X:      data = {4'd0, c.center_x};
                REG_CENTER_Y:      data = {4'd0, c.center_y};
                REG_GLYPH_SIZE:    data = {9'd0, c.size};
                REG_SCREEN_WIDTH:  data = {4'd0, c.width};
                default:           data = {4'd0, c.height};
            endcase
            cfg_we    <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= data;
            @(posedge aclk);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_we     <= 1'b0;
        active_cfg  = c;
    endtask

    // Offers one glyph pixel, after an optional idle gap, and holds it until the
    // block takes it. Must be entered at a rising edge; returns at the edge of
    // acceptance, with the prediction queued.
    task automatic send_pixel(input logic [7:0] cov, input logic [15:0] bg,
                              input logic [5:0] dx, input logic [5:0] dy);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_coverage   <= cov;
        s_background <= bg;
        s_col_offset <= dx;
        s_row_offset <= dy;
        do @(posedge aclk); while (!s_ready);
        expected_pixels.push_back(predict_pixel(active_cfg, cov, bg, dx, dy));
    endtask

    // A pixel whose offsets mostly fall inside the current glyph square.
    task automatic send_random_pixel(input int inside_pct);
        int          side;
        logic [5:0]  dx, dy;
        side = active_cfg.size;
        if (side > MAX_GLYPH_SIZE) side = MAX_GLYPH_SIZE;
        if (side > 0 && $urandom_range(0, 99) < inside_pct) begin
            dx = 6'($urandom_range(0, side - 1));
            dy = 6'($urandom_range(0, side - 1));
        end else begin
            dx = 6'($urandom);
            dy = 6'($urandom);
        end
        send_pixel(pick_coverage(), 16'($urandom), dx, dy);
    endtask

    // ------------------------------------------------------------------------
    // Sink pacing and result checking
    // ------------------------------------------------------------------------

    // The sink either honors a requested long hold-off, stalls for a random
    // stretch, or accepts for one cycle. m_ready is set once per pass.
    initial begin : sink_pacing
        int stall;
        forever begin
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                stall = 1 + pick_gap();
                repeat (stall) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Every output transaction is matched against the oldest prediction.
    always @(posedge aclk) begin : result_check
        pixel_write_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result with nothing pending", m_pixel_value, 32'd0);
            end else begin
                want = expected_pixels.pop_front();
                if (m_write_enable !== want.write_enable)
                    report_mismatch("write_enable", m_write_enable, want.write_enable);
                if (m_pixel_x !== want.x)
                    report_mismatch("pixel_x", m_pixel_x, want.x);
                if (m_pixel_y !== want.y)
                    report_mismatch("pixel_y", m_pixel_y, want.y);
                if (m_pixel_value !== want.value)
                    report_mismatch("pixel_value", m_pixel_value, want.value);
            end
        end
    end

    // Ends the run when no transaction on either channel has completed for
    // too long, which covers a hung pipeline and lost results alike.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Right after reset: white glyph of size 32 centered on 0,0 of a 240 by 240
    // screen, so only offsets of 16 and above land on the screen.
    task automatic test_reset_defaults();
        send_pixel(8'd255, 16'h0000, 6'd20, 6'd20);
        send_pixel(8'd0,   16'h1234, 6'd20, 6'd20);
        send_pixel(8'd128, 16'hFFFF, 6'd5,  6'd5);
    endtask

    // Opaque, faintest and half coverage over black and white
    // backgrounds, the last row and column inside the glyph, and offsets just
    // past and far past the glyph square.
    task automatic test_coverage_extremes();
        apply_settings(settings_of(16'($urandom), 1'b0, 120, 120, 32, 240, 240));
        send_pixel(8'd255, 16'h0000, 6'd0,  6'd0);
        send_pixel(8'd255, 16'hFFFF, 6'd31, 6'd31);
        send_pixel(8'd1,   16'hFFFF, 6'd10, 6'd10);
        send_pixel(8'd128, 16'hA5A5, 6'd31, 6'd0);
        send_pixel(8'd200, 16'h5A5A, 6'd32, 6'd5);
        send_pixel(8'd200, 16'h1234, 6'd5,  6'd63);
    endtask

    // The halo only joins the blend for coverage strictly above the threshold.
    task automatic test_halo_threshold();
        apply_settings(settings_of(16'hF81F, 1'b1, 60, 60, 16, 240, 240));
        send_pixel(8'd32,  16'h07E0, 6'd3, 6'd4);
        send_pixel(8'd33,  16'h07E0, 6'd3, 6'd4);
        send_pixel(8'd255, 16'h0000, 6'd15, 6'd15);
        send_pixel(8'd0,   16'h0000, 6'd1, 6'd1);
    endtask

    // A zero size drops everything, the largest register value saturates to
    // the maximum glyph, and a one-pixel glyph keeps only offset 0,0.
    task automatic test_glyph_size_limits();
        apply_settings(settings_of(16'h001F, 1'b0, 100, 100, 0, 240, 240));
        send_pixel(8'd255, 16'hFFFF, 6'd0, 6'd0);
        send_pixel(8'd90,  16'hFFFF, 6'd1, 6'd2);
        apply_settings(settings_of(16'hFFE0, 1'b1, 100, 100, 127, 240, 240));
        send_pixel(8'd255, 16'h8410, 6'd63, 6'd63);
        send_pixel(8'd100, 16'h8410, 6'd0,  6'd0);
        apply_settings(settings_of(16'h7BEF, 1'b0, 100, 100, 1, 240, 240));
        send_pixel(8'd255, 16'h0000, 6'd0, 6'd0);
        send_pixel(8'd255, 16'h0000, 6'd1, 6'd0);
    endtask

    // A zero-width screen clips everything; an oversized screen saturates so
    // that column and row 2047 are the last visible; the most negative
    // center puts the whole glyph off screen.
    task automatic test_screen_clipping();
        apply_settings(settings_of(16'hFFFF, 1'b0, 10, 10, 8, 0, 240));
        send_pixel(8'd255, 16'h0000, 6'd4, 6'd4);
        apply_settings(settings_of(16'h07FF, 1'b1, 2047, 2047, 4, 4095, 4095));
        send_pixel(8'd250, 16'h0000, 6'd2, 6'd2);
        send_pixel(8'd250, 16'h0000, 6'd3, 6'd2);
        apply_settings(settings_of(16'h07FF, 1'b0, -2048, -2048, 64, 2048, 2048));
        send_pixel(8'd255, 16'h0000, 6'd63, 6'd63);
    endtask

    // The sink holds off for a long stretch while the source keeps offering
    // back to back, so the pipeline fills and s_ready drops. The drain at the
    // end makes the source wait until every pending result is out.
    task automatic test_input_backpressure();
        apply_settings(settings_of(16'($urandom), 1'b1, 100, 100, 16, 240, 240));
        tx_gaps_on = 1'b0;
        rx_hold    = 1'b1;
        repeat (BACKPRESSURE_LEN) send_random_pixel(90);
        tx_gaps_on = 1'b1;
        drain_results();
    endtask

    // Random phases, each with fresh settings. Most pixels fall inside the glyph
    // square; the rest use arbitrary offsets. One phase in four runs with no
    // idling on either side.
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            apply_settings(random_settings());
            tx_gaps_on   = (phase % 4 != 3);
            rx_stalls_on = (phase % 4 != 3);
            repeat (ITEMS_PER_PHASE) send_random_pixel(85);
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial begin : sequencer
        // Predictor starts from the register defaults loaded by reset.
        active_cfg = settings_of(16'hFFFF, 1'b0, 0, 0, 32, 240, 240);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_reset_defaults();
        test_coverage_extremes();
        test_halo_threshold();
        test_glyph_size_limits();
        test_screen_clipping();
        test_input_backpressure();
        test_random_traffic();

        drain_results();
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
